// ===== hw/rtl/lpc_pkg.sv =====
// shared types, constants and aes helper functions for the payload cipher
`timescale 1ns / 1ps
`default_nettype none
package lpc_pkg;

   localparam logic [7:0] CTR_HEAD = 8'h01;
   localparam logic [7:0] BLK_FIRST = 8'h01;
   localparam logic [3:0] AES_LAST_ROUND = 4'd10;

   localparam logic [1:0] REG_APP_KEY_HIGH = 2'd0;
   localparam logic [1:0] REG_APP_KEY_LOW = 2'd1;
   localparam logic [1:0] REG_NET_KEY_HIGH = 2'd2;
   localparam logic [1:0] REG_NET_KEY_LOW = 2'd3;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        new_block;
      logic [3:0]  position;
      logic        key_select;
      logic [7:0]  direction;
      logic [31:0] dev_address;
      logic [31:0] frame_counter;
      logic [7:0]  block_count;
   } entry_type;

   typedef enum logic {
      BK_STREAM,
      BK_CIPHER
   } back_state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block sits at the top for i = 0
   function automatic logic [7:0] byte_at(input logic [127:0] x, input int i);
      byte_at = x[127 - 8 * i -: 8];
   endfunction

   // next round key from the current one
   function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                   input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t = {SBOX[byte_at(rk, 13)] ^ rcon, SBOX[byte_at(rk, 14)],
           SBOX[byte_at(rk, 15)], SBOX[byte_at(rk, 12)]};
      w0 = rk[127:96] ^ t;
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      next_round_key = {w0, w1, w2, w3};
   endfunction

   // sub bytes, shift rows, mix columns (skipped on the final round), add key
   function automatic logic [127:0] aes_round(input logic [127:0] st,
                                              input logic [127:0] rk,
                                              input logic final_round);
      logic [7:0] tmp [16];
      logic [7:0] a0;
      logic [7:0] a1;
      logic [7:0] a2;
      logic [7:0] a3;
      logic [127:0] res;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            tmp[j + 4 * c] = SBOX[byte_at(st, j + 4 * ((c + j) % 4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = tmp[4 * c];
         a1 = tmp[4 * c + 1];
         a2 = tmp[4 * c + 2];
         a3 = tmp[4 * c + 3];
         if (final_round) begin
            res[127 - 32 * c -: 32] = {a0, a1, a2, a3};
         end else begin
            res[127 - 32 * c -: 32] = {
               xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
         end
      end
      aes_round = res ^ rk;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lpc_if.sv =====
// valid/ready channel interfaces for payload bytes in and cipher bytes out
`timescale 1ns / 1ps
`default_nettype none
interface lpc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [31:0] dev_address;
   logic [7:0]  direction;
   logic [31:0] frame_counter;
   logic        use_network_key;
   modport source (output valid, data_byte, last_byte, dev_address, direction,
                   frame_counter, use_network_key, input ready);
   modport sink (input valid, data_byte, last_byte, dev_address, direction,
                 frame_counter, use_network_key, output ready);
endinterface

interface lpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, out_byte, out_last, input ready);
   modport sink (input valid, out_byte, out_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lorawan_payload_cipher.sv =====
// top level of the lorawan payload cipher: csr block, front, queue, back
`timescale 1ns / 1ps
`default_nettype none
//
// channel   | direction | handshake     | payload
// ----------+-----------+---------------+------------------------------------------
// req_ch    | in        | valid / ready | data_byte, last_byte, dev_address,
//           |           |               | direction, frame_counter, use_network_key
// rsp_ch    | out       | valid / ready | out_byte, out_last
// csr (apb) | in        | psel/penable  | 64-bit keys at byte address 8 * index
//
// one byte per cycle inside a 16-byte block while rsp_ch is not stalled; the first
// byte of every block waits for the iterative aes core (start, rounds, done)
// the queue lets the front keep taking bytes while the aes core runs
// reset is synchronous, active high; clears frame state, queue and output valid
// a stall on rsp_ch fills the queue, then drops req_ch.ready
//
module lorawan_payload_cipher
   import lpc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lpc_req_if.sink          req_ch,
   lpc_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   logic [63:0] app_hi_ff, app_lo_ff, net_hi_ff, net_lo_ff;
   logic        csr_write;
   logic [1:0]  reg_index;
   logic        push;
   entry_type   push_entry;
   logic        queue_full;
   logic        pop;
   entry_type   head;
   logic        head_valid;

   // register file, written on the apb access phase
   assign pready = 1'b1;
   assign reg_index = paddr[4:3];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_hi_ff <= '0;
         app_lo_ff <= '0;
         net_hi_ff <= '0;
         net_lo_ff <= '0;
      end else if (csr_write) begin
         case (reg_index)
            REG_APP_KEY_HIGH: app_hi_ff <= pwdata;
            REG_APP_KEY_LOW:  app_lo_ff <= pwdata;
            REG_NET_KEY_HIGH: net_hi_ff <= pwdata;
            REG_NET_KEY_LOW:  net_lo_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_APP_KEY_HIGH: prdata = app_hi_ff;
         REG_APP_KEY_LOW:  prdata = app_lo_ff;
         REG_NET_KEY_HIGH: prdata = net_hi_ff;
         REG_NET_KEY_LOW:  prdata = net_lo_ff;
         default:          prdata = '0;
      endcase
   end

   // front: frame tracking and block tagging
   lpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue between front and back
   lpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // back: keystream generation and xor into the output register
   lpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .app_key    ({app_hi_ff, app_lo_ff}),
      .net_key    ({net_hi_ff, net_lo_ff}),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/lpc_aes.sv =====
// iterative aes-128 encryption core, one round per cycle
`timescale 1ns / 1ps
`default_nettype none
module lpc_aes
   import lpc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] key,
   input  wire logic [127:0] block_in,
   output logic              done,
   output logic [127:0]      block_out
);

   logic         running_ff, running_in;
   logic         done_ff, done_in;
   logic [3:0]   round_ff, round_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [127:0] rkey_next;

   assign rkey_next = next_round_key(rkey_ff, rcon_ff);

   always_comb begin
      running_in = running_ff;
      done_in = 1'b0;
      round_in = round_ff;
      rcon_in = rcon_ff;
      state_in = state_ff;
      rkey_in = rkey_ff;
      if (start) begin
         running_in = 1'b1;
         round_in = 4'd1;
         rcon_in = 8'h01;
         state_in = block_in ^ key;
         rkey_in = key;
      end else if (running_ff) begin
         state_in = aes_round(state_ff, rkey_next, round_ff == AES_LAST_ROUND);
         rkey_in = rkey_next;
         rcon_in = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == AES_LAST_ROUND) begin
            running_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff <= done_in;
      end
      round_ff <= round_in;
      rcon_ff <= rcon_in;
      state_ff <= state_in;
      rkey_ff <= rkey_in;
   end

   assign done = done_ff;
   assign block_out = state_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lpc_queue.sv =====
// small fifo of classified bytes between front and back
`timescale 1ns / 1ps
`default_nettype none
module lpc_queue
   import lpc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output entry_type      head,
   output logic           head_valid
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type    slots_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      wr_in = push ? bump(wr_ff) : wr_ff;
      rd_in = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

   assign full = count_ff == CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head = slots_ff[rd_ff];

endmodule
`default_nettype wire

// ===== hw/rtl/lpc_front.sv =====
// front end: takes bytes, tracks frame and block position, tags block starts
`timescale 1ns / 1ps
`default_nettype none
module lpc_front
   import lpc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   lpc_req_if.sink    req_ch,
   input  wire logic  queue_full,
   output logic       push,
   output entry_type  push_entry
);

   logic        open_ff, open_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  blk_ff, blk_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  dir_ff, dir_in;
   logic [31:0] fcnt_ff, fcnt_in;
   logic        ksel_ff, ksel_in;
   logic [3:0]  cur_pos;
   logic [7:0]  cur_blk;

   assign req_ch.ready = !queue_full;
   assign push = req_ch.valid && !queue_full;

   always_comb begin
      // a closed frame restarts on this byte with fresh frame fields
      if (open_ff) begin
         cur_pos = pos_ff;
         cur_blk = blk_ff;
         addr_in = addr_ff;
         dir_in = dir_ff;
         fcnt_in = fcnt_ff;
         ksel_in = ksel_ff;
      end else begin
         cur_pos = '0;
         cur_blk = BLK_FIRST;
         addr_in = req_ch.dev_address;
         dir_in = req_ch.direction;
         fcnt_in = req_ch.frame_counter;
         ksel_in = req_ch.use_network_key;
      end
      pos_in = cur_pos + 4'd1;
      blk_in = (cur_pos == 4'hf) ? cur_blk + 8'd1 : cur_blk;
      open_in = !req_ch.last_byte;

      push_entry.data_byte = req_ch.data_byte;
      push_entry.last_byte = req_ch.last_byte;
      push_entry.new_block = cur_pos == '0;
      push_entry.position = cur_pos;
      push_entry.key_select = ksel_in;
      push_entry.direction = dir_in;
      push_entry.dev_address = addr_in;
      push_entry.frame_counter = fcnt_in;
      push_entry.block_count = cur_blk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         pos_ff <= '0;
         blk_ff <= BLK_FIRST;
      end else if (push) begin
         open_ff <= open_in;
         pos_ff <= pos_in;
         blk_ff <= blk_in;
      end
      if (push) begin
         addr_ff <= addr_in;
         dir_ff <= dir_in;
         fcnt_ff <= fcnt_in;
         ksel_ff <= ksel_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lpc_back.sv =====
// back end: runs aes per block, xors bytes with keystream, holds the output
`timescale 1ns / 1ps
`default_nettype none
module lpc_back
   import lpc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire entry_type    head,
   input  wire logic         head_valid,
   output logic              pop,
   input  wire logic [127:0] app_key,
   input  wire logic [127:0] net_key,
   lpc_rsp_if.source         rsp_ch
);

   back_state_type state_ff, state_in;
   logic           fresh_ff, fresh_in;
   logic           valid_ff, valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           last_ff, last_in;
   logic           aes_start;
   logic           aes_done;
   logic [127:0]   keystream;
   logic [127:0]   ctr_block;
   logic           out_free;
   logic           need_block;
   logic [6:0]     ks_lsb;

   assign ctr_block = {CTR_HEAD, 32'h0, head.direction,
                       head.dev_address[7:0], head.dev_address[15:8],
                       head.dev_address[23:16], head.dev_address[31:24],
                       head.frame_counter[7:0], head.frame_counter[15:8],
                       head.frame_counter[23:16], head.frame_counter[31:24],
                       8'h00, head.block_count};

   lpc_aes u_aes (
      .clock     (clock),
      .reset     (reset),
      .start     (aes_start),
      .key       (head.key_select ? net_key : app_key),
      .block_in  (ctr_block),
      .done      (aes_done),
      .block_out (keystream)
   );

   assign out_free = !valid_ff || rsp_ch.ready;
   assign need_block = head_valid && head.new_block && !fresh_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_STREAM: begin
            if (need_block) begin
               state_in = BK_CIPHER;
            end
         end
         BK_CIPHER: begin
            if (aes_done) begin
               state_in = BK_STREAM;
            end
         end
         default: state_in = BK_STREAM;
      endcase
   end

   always_comb begin
      aes_start = 1'b0;
      pop = 1'b0;
      case (state_ff)
         BK_STREAM: begin
            aes_start = need_block;
            pop = head_valid && !need_block && out_free;
         end
         BK_CIPHER: begin
            aes_start = 1'b0;
            pop = 1'b0;
         end
         default: begin
            aes_start = 1'b0;
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      ks_lsb = {~head.position, 3'b000};
      fresh_in = aes_done ? 1'b1 : (pop ? 1'b0 : fresh_ff);
      valid_in = pop || (valid_ff && !rsp_ch.ready);
      byte_in = pop ? head.data_byte ^ keystream[ks_lsb +: 8] : byte_ff;
      last_in = pop ? head.last_byte : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_STREAM;
         fresh_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fresh_ff <= fresh_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.out_last = last_ff;

endmodule
`default_nettype wire

// ===== sim/tb_lorawan_payload_cipher.sv =====
// self-checking testbench for the lorawan payload cipher top level
`timescale 1ns / 1ps
module tb_lorawan_payload_cipher;
   import lpc_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_out_type;

   // directed stimulus row: n bytes counting up from data, last set on the final one if last is set
   typedef struct {
      logic [7:0]  data;
      int          count;
      logic        last;
      logic [31:0] addr;
      logic [7:0]  dir;
      logic [31:0] fcnt;
      logic        net_key;
   } frame_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [4:0] paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic pready;

   lpc_req_if req_ch ();
   lpc_rsp_if rsp_ch ();

   lorawan_payload_cipher uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state, mirrors the cipher after reset
   logic [63:0]  key_regs [4];
   logic [127:0] ks_block;
   logic [3:0]   ks_pos;
   logic [7:0]   ks_blk_cnt;
   logic         frm_open;
   logic [31:0]  frm_addr;
   logic [7:0]   frm_dir;
   logic [31:0]  frm_fcnt;
   logic         frm_net_key;

   cipher_out_type expected_bytes [$];
   int  fail_count;
   int  bytes_sent;
   int  bytes_checked;
   int  frames_sent;
   bit  src_burst;
   bit  sink_burst;
   bit  hold_req;

   frame_row_type frame_rows [] = '{
      // single-byte frames, two at the field extremes, app and network key
      '{8'h00, 1, 1'b1, 32'h0000_0000, 8'h00, 32'h0000_0000, 1'b0},
      '{8'hff, 1, 1'b1, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1'b1},
      '{8'h5a, 1, 1'b1, 32'h2601_1234, 8'h01, 32'h0000_0001, 1'b0},
      // direction value outside 0/1 still feeds the counter block
      '{8'ha5, 1, 1'b1, 32'h2601_1234, 8'h82, 32'h0000_0001, 1'b1},
      // 18-byte frame, crosses a block and ends partial; header changes mid-frame are ignored
      '{8'h10, 10, 1'b0, 32'h0102_0304, 8'h00, 32'h0000_0010, 1'b0},
      '{8'h80, 8, 1'b1, 32'hdead_beef, 8'h01, 32'h9999_9999, 1'b1},
      // exactly one block on the network key
      '{8'hf0, 16, 1'b1, 32'h8000_0001, 8'h01, 32'h8000_0000, 1'b1}
   };

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // aes-128 encryption of one block, byte 0 in the top bits
   function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                input logic [127:0] blk);
      logic [7:0] rk [176];
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] t [4];
      logic [7:0] rc;
      logic [7:0] first;
      logic [7:0] a0;
      logic [7:0] a1;
      logic [7:0] a2;
      logic [7:0] a3;
      logic [127:0] res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
         if (i % 16 == 0) begin
            first = t[0];
            t[0] = SBOX[t[1]] ^ rc;
            t[1] = SBOX[t[2]];
            t[2] = SBOX[t[3]];
            t[3] = SBOX[first];
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end
         for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ t[j];
      end
      for (int i = 0; i < 16; i++) st[i] = blk[127 - 8 * i -: 8] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
               tmp[j + 4 * c] = SBOX[st[j + 4 * ((c + j) % 4)]];
         for (int c = 0; c < 4; c++) begin
            a0 = tmp[4 * c];
            a1 = tmp[4 * c + 1];
            a2 = tmp[4 * c + 2];
            a3 = tmp[4 * c + 3];
            if (r == 10) begin
               st[4 * c] = a0;
               st[4 * c + 1] = a1;
               st[4 * c + 2] = a2;
               st[4 * c + 3] = a3;
            end else begin
               st[4 * c] = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
               st[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
               st[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
               st[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16 * r + i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
      return res;
   endfunction

   // advance the predictor by one accepted byte and queue its cipher byte
   function automatic void predict_cipher_byte(input logic [7:0] data, input logic last);
      logic [127:0] ctr;
      logic [127:0] key;
      cipher_out_type exp_out;
      if (!frm_open) begin
         frm_addr = req_ch.dev_address;
         frm_dir = req_ch.direction;
         frm_fcnt = req_ch.frame_counter;
         frm_net_key = req_ch.use_network_key;
         ks_blk_cnt = BLK_FIRST;
         ks_pos = 4'd0;
         frm_open = 1'b1;
      end
      if (ks_pos == 4'd0) begin
         // keys are picked up at each block start
         key = frm_net_key ? {key_regs[REG_NET_KEY_HIGH], key_regs[REG_NET_KEY_LOW]}
                           : {key_regs[REG_APP_KEY_HIGH], key_regs[REG_APP_KEY_LOW]};
         ctr = {CTR_HEAD, 32'h0, frm_dir,
                frm_addr[7:0], frm_addr[15:8], frm_addr[23:16], frm_addr[31:24],
                frm_fcnt[7:0], frm_fcnt[15:8], frm_fcnt[23:16], frm_fcnt[31:24],
                8'h00, ks_blk_cnt};
         ks_block = aes_encrypt(key, ctr);
      end
      exp_out.out_byte = data ^ ks_block[127 - 8 * ks_pos -: 8];
      exp_out.out_last = last;
      expected_bytes.push_back(exp_out);
      ks_pos = ks_pos + 4'd1;
      if (ks_pos == 4'd0) ks_blk_cnt = ks_blk_cnt + 8'd1;
      if (last) frm_open = 1'b0;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #80_000_000;
      $display("Verification failed");
      $finish;
   end

   // apb write: setup cycle, then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 3'b000};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      key_regs[idx] = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // offer one byte after a random gap, wait for the transaction
   task automatic send_byte(input logic [7:0] data, input logic last, input logic [31:0] addr,
                            input logic [7:0] dir, input logic [31:0] fcnt,
                            input logic net_key);
      int gap;
      gap = src_burst ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data_byte = data;
      req_ch.last_byte = last;
      req_ch.dev_address = addr;
      req_ch.direction = dir;
      req_ch.frame_counter = fcnt;
      req_ch.use_network_key = net_key;
      do @(posedge clock); while (!req_ch.ready);
      predict_cipher_byte(data, last);
      bytes_sent++;
      if (last) frames_sent++;
   endtask

   task automatic idle_input();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // wait until every expected byte is back, plus the aes latency
   task automatic drain();
      idle_input();
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // random frame; header fields are random on every byte, only the first one counts
   task automatic send_frame(input int len);
      logic [7:0] dir;
      for (int k = 0; k < len; k++) begin
         dir = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
         send_byte(8'($urandom), k == len - 1, $urandom, dir, $urandom,
                   1'($urandom));
      end
   endtask

   // result side: random stall per transaction, long hold on request
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ch.ready = 1'b0;
            repeat (300) @(negedge clock);
            hold_req = 1'b0;
         end
         stall = sink_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      cipher_out_type exp_out;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %h out_last %b",
                   rsp_ch.out_byte, rsp_ch.out_last);
            fail_count++;
         end else begin
            exp_out = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_ch.out_byte !== exp_out.out_byte) begin
               $error("out_byte: expected %h actual %h", exp_out.out_byte, rsp_ch.out_byte);
               fail_count++;
            end
            if (rsp_ch.out_last !== exp_out.out_last) begin
               $error("out_last: expected %b actual %b", exp_out.out_last, rsp_ch.out_last);
               fail_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      int wait_cnt;
      fail_count = 0;
      bytes_sent = 0;
      bytes_checked = 0;
      frames_sent = 0;
      src_burst = 1'b0;
      sink_burst = 1'b0;
      hold_req = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      req_ch.dev_address = '0;
      req_ch.direction = '0;
      req_ch.frame_counter = '0;
      req_ch.use_network_key = 1'b0;
      for (int i = 0; i < 4; i++) key_regs[i] = '0;
      ks_block = '0;
      ks_pos = '0;
      ks_blk_cnt = BLK_FIRST;
      frm_open = 1'b0;
      frm_addr = '0;
      frm_dir = '0;
      frm_fcnt = '0;
      frm_net_key = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, keys still at reset (all zero)
      foreach (frame_rows[r]) begin
         for (int k = 0; k < frame_rows[r].count; k++)
            send_byte(frame_rows[r].data + 8'(k),
                      frame_rows[r].last && (k == frame_rows[r].count - 1),
                      frame_rows[r].addr, frame_rows[r].dir, frame_rows[r].fcnt,
                      frame_rows[r].net_key);
      end
      drain();

      // key extremes, then a key change in the middle of an open frame
      csr_write(REG_APP_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
      csr_write(REG_APP_KEY_LOW, 64'hffff_ffff_ffff_ffff);
      csr_write(REG_NET_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
      csr_write(REG_NET_KEY_LOW, 64'habf7_1588_09cf_4f3c);
      for (int k = 0; k < 5; k++)
         send_byte(8'(k), 1'b0, 32'h0000_00aa, 8'h00, 32'h0000_0005, 1'b0);
      drain();
      // new app key takes effect at the next block of this frame
      csr_write(REG_APP_KEY_LOW, 64'h0);
      for (int k = 0; k < 20; k++)
         send_byte(8'hff - 8'(k), k == 19, 32'h0, 8'h0, 32'h0, 1'b1);
      drain();

      // random part: phases of random frames under different key settings
      for (int phase = 0; bytes_sent < 1900; phase++) begin
         for (int i = 0; i < 4; i++)
            csr_write(i[1:0], (phase % 5 == 1) ? 64'h0 :
                      (phase % 5 == 2) ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom});
         // some phases run without idling on one or both sides
         src_burst = (phase % 3 == 1);
         sink_burst = (phase % 4 == 2);
         for (int f = 0; f < 12; f++) begin
            if (f == 3 && phase % 2 == 0) begin
               // stall the output a long time while bytes keep coming
               src_burst = 1'b1;
               hold_req = 1'b1;
            end
            if (f == 7) begin
               // pause until the block has emptied
               src_burst = (phase % 3 == 1);
               drain();
            end
            send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(33, 70)
                                                    : $urandom_range(1, 32));
         end
         drain();
      end
      idle_input();

      wait_cnt = 0;
      while (expected_bytes.size() != 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (40) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", expected_bytes.size());
         fail_count++;
      end

      $display("run covered %0d payload bytes in %0d frames, %0d cipher bytes checked",
               bytes_sent, frames_sent, bytes_checked);
      $display("key extremes, mid-frame key change and long output stalls included");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
